// File: sv/lennard_jones_pair_force_defines.svh
// Assertion macros shared by the Lennard-Jones pair force block.
`ifndef LENNARD_JONES_PAIR_FORCE_DEFINES_SVH
`define LENNARD_JONES_PAIR_FORCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LJPF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LJPF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ljpf_pkg.sv
// Shared types and constants of the Lennard-Jones pair force block.
package ljpf_pkg;

   localparam int CSR_IDX_W   = 4;
   localparam int OPND_W      = 64;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int MUL_STEPS   = 4;
   localparam int RECIP_BITS  = 64;
   localparam int SUM_W       = 48;

   localparam logic [CSR_IDX_W-1:0] REG_BOX_XY   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0     = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FCOEF    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ECOEF    = 4'd7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRAP,
      S_MUL,
      S_WAIT,
      S_CHECK,
      S_DIV,
      S_DIVW,
      S_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_MAT,
      OP_SQ,
      OP_P4,
      OP_P6,
      OP_P8,
      OP_P12,
      OP_P14,
      OP_TF8,
      OP_TF14,
      OP_TE12,
      OP_TE6,
      OP_FRC
   } op_type;

endpackage

// File: sv/lennard_jones_pair_force.sv
// Top level of the Lennard-Jones 12-6 pair force accumulator.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_valid/req_stall  home and neighbor positions, flags
//   rsp      out        rsp_valid/rsp_stall  force sums and potential energy
//   csr      in         csr_valid/csr_ready  register index and 64-bit data
//
// A word with pair_valid low goes straight to the final state; a computed pair makes 24 passes
// through the shared multiplier, one run of the reciprocal and the sequencing states.
// A pair beyond the cutoff or with zero distance ends after the squaring passes, before the reciprocal.
// Synchronous reset clears the configuration registers, running sums, the result valid flag and the sequencer.
// A result waiting under rsp_stall holds the next emitting word in its final state.
`include "lennard_jones_pair_force_defines.svh"
module lennard_jones_pair_force (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_home_x,
   input  logic [31:0]                     req_home_y,
   input  logic [31:0]                     req_home_z,
   input  logic [31:0]                     req_nbr_x,
   input  logic [31:0]                     req_nbr_y,
   input  logic [31:0]                     req_nbr_z,
   input  logic                            req_pair_valid,
   input  logic                            req_last_neighbor,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [47:0]              rsp_force_x,
   output logic signed [47:0]              rsp_force_y,
   output logic signed [47:0]              rsp_force_z,
   output logic signed [47:0]              rsp_pot_energy,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ljpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [63:0]                     csr_data
);
   import ljpf_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] s,
      input logic signed [SUM_W-1:0] c
   );
      logic signed [SUM_W:0] r;
      r = $signed({s[SUM_W-1], s}) + $signed({c[SUM_W-1], c});
      if (r > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
         return SUM_MAX;
      end else if (r < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
         return SUM_MIN;
      end
      return r[SUM_W-1:0];
   endfunction

   logic [63:0]          box_xy_ff;
   logic [31:0]          box_z_ff;
   logic [62:0]          row_ff [3];
   logic [31:0]          cut_ff;
   logic [63:0]          fco_ff;
   logic [63:0]          eco_ff;

   logic [31:0]          home_ff [3];
   logic [31:0]          nbr_ff [3];
   logic                 pvalid_ff;
   logic                 last_ff;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [1:0]           i_ff, i_in;
   logic [1:0]           k_ff, k_in;

   logic signed [34:0]   d_ff [3];
   logic signed [34:0]   d_wrap [3];
   logic signed [31:0]   t_ff [3];
   logic signed [57:0]   s_ff;
   logic [63:0]          r2_ff;
   logic [63:0]          i2_ff, i4_ff, i6_ff, i8_ff, i12_ff, i14_ff;
   logic [61:0]          tf_ff;
   logic [61:0]          te_ff;
   logic signed [63:0]   f_ff;

   logic signed [SUM_W-1:0] sum_fx_ff, sum_fy_ff, sum_fz_ff, sum_pe_ff;
   logic signed [SUM_W-1:0] out_fx_ff, out_fy_ff, out_fz_ff, out_pe_ff;
   logic                 rsp_valid_ff;

   logic                 mul_start, mul_done;
   logic [OPND_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]    mul_prod;
   logic                 div_start, div_done;
   logic [OPND_W-1:0]    div_quo;
   logic                 emit;

   logic [31:0]          len_ax [3];
   logic signed [34:0]   dd, len35, half35;
   logic [20:0]          m_raw, m_mag;
   logic signed [34:0]   d_sel;
   logic [34:0]          d_mag;
   logic signed [31:0]   t_sel;
   logic [31:0]          t_mag;
   logic [63:0]          f_mag;
   logic signed [57:0]   mat_part, s_sum, s_abs;
   logic [38:0]          s_q;
   logic signed [31:0]   t_new;
   logic [63:0]          pw_val;
   logic [61:0]          term_val;
   logic [46:0]          fm_val;
   logic signed [63:0]   f_new, e_diff, e_half;
   logic signed [SUM_W-1:0] e_cl, frc_part;
   logic                 skip;
   logic                 accept;

   assign accept = req_valid && !req_stall;

   ljpf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .opnd_a (mul_a),
      .opnd_b (mul_b),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   ljpf_recip u_recip (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .den   (r2_ff[55:24]),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         box_xy_ff <= '0;
         box_z_ff  <= '0;
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= '0;
         cut_ff    <= '0;
         fco_ff    <= '0;
         eco_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BOX_XY: begin
               box_xy_ff <= csr_data;
            end
            REG_BOX_Z: begin
               box_z_ff <= csr_data[31:0];
            end
            REG_ROW0: begin
               row_ff[0] <= csr_data[62:0];
            end
            REG_ROW1: begin
               row_ff[1] <= csr_data[62:0];
            end
            REG_ROW2: begin
               row_ff[2] <= csr_data[62:0];
            end
            REG_CUTOFF: begin
               cut_ff <= csr_data[31:0];
            end
            REG_FCOEF: begin
               fco_ff <= csr_data;
            end
            REG_ECOEF: begin
               eco_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      len_ax[0] = box_xy_ff[31:0];
      len_ax[1] = box_xy_ff[63:32];
      len_ax[2] = box_z_ff;
      dd     = '0;
      len35  = '0;
      half35 = '0;
      for (int a = 0; a < 3; a++) begin
         dd     = $signed({3'b000, nbr_ff[a]}) - $signed({3'b000, home_ff[a]});
         len35  = $signed({3'b000, len_ax[a]});
         half35 = $signed({4'b0000, len_ax[a][31:1]});
         if (dd > half35) begin
            d_wrap[a] = dd - len35;
         end else if (dd < -half35) begin
            d_wrap[a] = dd + len35;
         end else begin
            d_wrap[a] = dd;
         end
      end
   end

   always_comb begin
      m_raw = row_ff[k_ff][21*i_ff +: 21];
      m_mag = m_raw[20] ? (~m_raw + 21'd1) : m_raw;
      d_sel = d_ff[k_ff];
      d_mag = d_sel[34] ? 35'(-d_sel) : 35'(d_sel);
      t_sel = t_ff[i_ff];
      t_mag = t_sel[31] ? 32'(-t_sel) : 32'(t_sel);
      f_mag = f_ff[63] ? 64'(-f_ff) : 64'(f_ff);

      case (op_ff)
         OP_MAT: begin
            mul_a = {29'd0, d_mag};
            mul_b = {43'd0, m_mag};
         end
         OP_SQ: begin
            mul_a = {32'd0, t_mag};
            mul_b = {32'd0, t_mag};
         end
         OP_P4: begin
            mul_a = i2_ff;
            mul_b = i2_ff;
         end
         OP_P6: begin
            mul_a = i2_ff;
            mul_b = i4_ff;
         end
         OP_P8: begin
            mul_a = i4_ff;
            mul_b = i4_ff;
         end
         OP_P12: begin
            mul_a = i4_ff;
            mul_b = i8_ff;
         end
         OP_P14: begin
            mul_a = i6_ff;
            mul_b = i8_ff;
         end
         OP_TF8: begin
            mul_a = {32'd0, fco_ff[31:0]};
            mul_b = i8_ff;
         end
         OP_TF14: begin
            mul_a = {32'd0, fco_ff[63:32]};
            mul_b = i14_ff;
         end
         OP_TE12: begin
            mul_a = {32'd0, eco_ff[31:0]};
            mul_b = i12_ff;
         end
         OP_TE6: begin
            mul_a = {32'd0, eco_ff[63:32]};
            mul_b = i6_ff;
         end
         OP_FRC: begin
            mul_a = f_mag;
            mul_b = {32'd0, t_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      mat_part = (d_sel[34] ^ m_raw[20]) ? -$signed({2'b00, mul_prod[55:0]})
                                         : $signed({2'b00, mul_prod[55:0]});
      s_sum = s_ff + mat_part;
      s_abs = s_sum[57] ? -s_sum : s_sum;
      s_q   = s_abs[57:19];
      if (!s_sum[57]) begin
         t_new = (s_q > 39'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(s_q[31:0]);
      end else begin
         t_new = (s_q > 39'h0080000000) ? 32'sh80000000 : -$signed(s_q[31:0]);
      end

      pw_val   = (|mul_prod[127:104]) ? {64{1'b1}} : mul_prod[103:40];
      term_val = (|mul_prod[127:94]) ? {62{1'b1}} : mul_prod[93:32];
      fm_val   = (|mul_prod[127:71]) ? {47{1'b1}} : mul_prod[70:24];

      f_new  = $signed({2'b00, tf_ff}) - $signed({2'b00, term_val});
      e_diff = $signed({2'b00, te_ff}) - $signed({2'b00, term_val});
      e_half = (e_diff + $signed({63'd0, e_diff[63]})) >>> 1;
      if (e_half > $signed(64'(SUM_MAX))) begin
         e_cl = SUM_MAX;
      end else if (e_half < -$signed(64'(SUM_MAX))) begin
         e_cl = -SUM_MAX;
      end else begin
         e_cl = e_half[SUM_W-1:0];
      end

      frc_part = (f_ff[63] ^ t_sel[31]) ? -$signed({1'b0, fm_val})
                                        : $signed({1'b0, fm_val});

      skip = (r2_ff > {8'd0, cut_ff, 24'd0}) || (r2_ff[63:24] == 40'd0);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = req_pair_valid ? S_WRAP : S_FIN;
            end
         end
         S_WRAP: begin
            op_in    = OP_MAT;
            i_in     = 2'd0;
            k_in     = 2'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            mul_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (mul_done) begin
               state_in = S_MUL;
               case (op_ff)
                  OP_MAT: begin
                     if (k_ff == 2'd2) begin
                        k_in = 2'd0;
                        if (i_ff == 2'd2) begin
                           i_in  = 2'd0;
                           op_in = OP_SQ;
                        end else begin
                           i_in = i_ff + 2'd1;
                        end
                     end else begin
                        k_in = k_ff + 2'd1;
                     end
                  end
                  OP_SQ: begin
                     if (i_ff == 2'd2) begin
                        state_in = S_CHECK;
                     end else begin
                        i_in = i_ff + 2'd1;
                     end
                  end
                  OP_P4: begin
                     op_in = OP_P6;
                  end
                  OP_P6: begin
                     op_in = OP_P8;
                  end
                  OP_P8: begin
                     op_in = OP_P12;
                  end
                  OP_P12: begin
                     op_in = OP_P14;
                  end
                  OP_P14: begin
                     op_in = OP_TF8;
                  end
                  OP_TF8: begin
                     op_in = OP_TF14;
                  end
                  OP_TF14: begin
                     op_in = OP_TE12;
                  end
                  OP_TE12: begin
                     op_in = OP_TE6;
                  end
                  OP_TE6: begin
                     op_in = OP_FRC;
                     i_in  = 2'd0;
                  end
                  OP_FRC: begin
                     if (i_ff == 2'd2) begin
                        state_in = S_FIN;
                     end else begin
                        i_in = i_ff + 2'd1;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            state_in = skip ? S_FIN : S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in  = S_DIVW;
         end
         S_DIVW: begin
            if (div_done) begin
               op_in    = OP_P4;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_MAT;
         i_ff     <= 2'd0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (accept) begin
         home_ff[0] <= req_home_x;
         home_ff[1] <= req_home_y;
         home_ff[2] <= req_home_z;
         nbr_ff[0]  <= req_nbr_x;
         nbr_ff[1]  <= req_nbr_y;
         nbr_ff[2]  <= req_nbr_z;
         pvalid_ff  <= req_pair_valid;
         last_ff    <= req_last_neighbor;
      end
      if (state_ff == S_WRAP) begin
         d_ff[0] <= d_wrap[0];
         d_ff[1] <= d_wrap[1];
         d_ff[2] <= d_wrap[2];
         s_ff    <= '0;
         r2_ff   <= '0;
      end
      if (state_ff == S_DIVW && div_done) begin
         i2_ff <= div_quo;
      end
      if (state_ff == S_WAIT && mul_done) begin
         case (op_ff)
            OP_MAT: begin
               if (k_ff == 2'd2) begin
                  t_ff[i_ff] <= t_new;
                  s_ff       <= '0;
               end else begin
                  s_ff <= s_sum;
               end
            end
            OP_SQ: begin
               r2_ff <= r2_ff + mul_prod[63:0];
            end
            OP_P4: begin
               i4_ff <= pw_val;
            end
            OP_P6: begin
               i6_ff <= pw_val;
            end
            OP_P8: begin
               i8_ff <= pw_val;
            end
            OP_P12: begin
               i12_ff <= pw_val;
            end
            OP_P14: begin
               i14_ff <= pw_val;
            end
            OP_TF8: begin
               tf_ff <= term_val;
            end
            OP_TF14: begin
               f_ff <= f_new;
            end
            OP_TE12: begin
               te_ff <= term_val;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_fx_ff <= '0;
         sum_fy_ff <= '0;
         sum_fz_ff <= '0;
         sum_pe_ff <= '0;
      end else if (emit) begin
         sum_fx_ff <= '0;
         sum_fy_ff <= '0;
         sum_fz_ff <= '0;
         sum_pe_ff <= '0;
      end else if (state_ff == S_WAIT && mul_done) begin
         if (op_ff == OP_TE6) begin
            sum_pe_ff <= sat_add(sum_pe_ff, e_cl);
         end else if (op_ff == OP_FRC) begin
            case (i_ff)
               2'd0: begin
                  sum_fx_ff <= sat_add(sum_fx_ff, frc_part);
               end
               2'd1: begin
                  sum_fy_ff <= sat_add(sum_fy_ff, frc_part);
               end
               default: begin
                  sum_fz_ff <= sat_add(sum_fz_ff, frc_part);
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= emit || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_fx_ff <= sum_fx_ff;
         out_fy_ff <= sum_fy_ff;
         out_fz_ff <= sum_fz_ff;
         out_pe_ff <= sum_pe_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_x    = out_fx_ff;
   assign rsp_force_y    = out_fy_ff;
   assign rsp_force_z    = out_fz_ff;
   assign rsp_pot_energy = out_pe_ff;

   `LJPF_ASSERT_IMP(a_mul_done_in_wait, clock, reset, mul_done, state_ff == S_WAIT, "multiplier finished outside its wait state")
   `LJPF_ASSERT_IMP(a_div_done_in_wait, clock, reset, div_done, state_ff == S_DIVW, "reciprocal finished outside its wait state")
   `LJPF_ASSERT_NXT(a_emit_clears_sums, clock, reset, emit, rsp_valid_ff && sum_fx_ff == '0 && sum_pe_ff == '0, "emitted word did not clear the sums")
   `LJPF_ASSERT_IMP(a_invalid_pair_skips, clock, reset, state_ff == S_WRAP, pvalid_ff, "sequencer started on a word without a pair")

endmodule

// File: sv/ljpf_mul.sv
// Shared 64 by 64 unsigned multiplier built from one 32 by 32 product per cycle.
module ljpf_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ljpf_pkg::OPND_W-1:0]   opnd_a,
   input  logic [ljpf_pkg::OPND_W-1:0]   opnd_b,
   output logic                          done,
   output logic [ljpf_pkg::PROD_W-1:0]   prod
);
   import ljpf_pkg::*;

   localparam int HALF_W = OPND_W / 2;

   logic                run_ff;
   logic                done_ff;
   logic [2:0]          cnt_ff;
   logic [OPND_W-1:0]   a_ff;
   logic [OPND_W-1:0]   b_ff;
   logic [OPND_W-1:0]   p_ff;
   logic [1:0]          psh_ff;
   logic [PROD_W-1:0]   acc_ff;
   logic [HALF_W-1:0]   a_half;
   logic [HALF_W-1:0]   b_half;
   logic [OPND_W-1:0]   part_in;
   logic [PROD_W-1:0]   shifted;

   always_comb begin
      a_half  = cnt_ff[1] ? a_ff[OPND_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half  = cnt_ff[0] ? b_ff[OPND_W-1:HALF_W] : b_ff[HALF_W-1:0];
      part_in = a_half * b_half;
      case (psh_ff)
         2'd0: begin
            shifted = {{OPND_W{1'b0}}, p_ff};
         end
         2'd1, 2'd2: begin
            shifted = {{HALF_W{1'b0}}, p_ff, {HALF_W{1'b0}}};
         end
         default: begin
            shifted = {p_ff, {OPND_W{1'b0}}};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 3'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'(MUL_STEPS)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= opnd_a;
         b_ff   <= opnd_b;
         acc_ff <= '0;
      end else if (run_ff) begin
         if (cnt_ff != 3'(MUL_STEPS)) begin
            p_ff   <= part_in;
            psh_ff <= cnt_ff[1:0];
         end
         if (cnt_ff != 3'd0) begin
            acc_ff <= acc_ff + shifted;
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// File: sv/ljpf_recip.sv
// Restoring divider that forms floor((2^64 - 1) / den) one quotient bit per cycle.
module ljpf_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   den,
   output logic                          done,
   output logic [ljpf_pkg::OPND_W-1:0]   quo
);
   import ljpf_pkg::*;

   logic                run_ff;
   logic                done_ff;
   logic [5:0]          cnt_ff;
   logic [31:0]         den_ff;
   logic [31:0]         rem_ff;
   logic [OPND_W-1:0]   quo_ff;
   logic [32:0]         trial;
   logic [32:0]         diff;
   logic                ge;

   always_comb begin
      trial = {rem_ff, 1'b1};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(RECIP_BITS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= 32'd0;
      end else if (run_ff) begin
         rem_ff <= ge ? diff[31:0] : trial[31:0];
         quo_ff <= {quo_ff[OPND_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: dv/lennard_jones_pair_force_tb.sv
// Self-checking testbench for the Lennard-Jones pair force accumulator.
`timescale 1ns / 100ps

class force_sum_board;
   logic signed [47:0] exp_fx[$];
   logic signed [47:0] exp_fy[$];
   logic signed [47:0] exp_fz[$];
   logic signed [47:0] exp_pe[$];
   int unsigned errors;
   logic [63:0] box_xy, box_z, row[3], cut_sq, fcoef, ecoef;
   longint sfx, sfy, sfz, spe;

   function new();
      errors = 0;
      clear_regs();
   endfunction

   function void clear_regs();
      box_xy = 0; box_z = 0; row[0] = 0; row[1] = 0; row[2] = 0;
      cut_sq = 0; fcoef = 0; ecoef = 0;
      sfx = 0; sfy = 0; sfz = 0; spe = 0;
   endfunction

   function void write_reg(logic [3:0] idx, logic [63:0] val);
      case (idx)
         ljpf_pkg::REG_BOX_XY: box_xy = val;
         ljpf_pkg::REG_BOX_Z: box_z = {32'd0, val[31:0]};
         ljpf_pkg::REG_ROW0: row[0] = {1'b0, val[62:0]};
         ljpf_pkg::REG_ROW1: row[1] = {1'b0, val[62:0]};
         ljpf_pkg::REG_ROW2: row[2] = {1'b0, val[62:0]};
         ljpf_pkg::REG_CUTOFF: cut_sq = {32'd0, val[31:0]};
         ljpf_pkg::REG_FCOEF: fcoef = val;
         ljpf_pkg::REG_ECOEF: ecoef = val;
         default: ;
      endcase
   endfunction

   function logic [63:0] scaled_mul(logic [63:0] a, logic [63:0] b, int s, logic [63:0] cap);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> s;
      if (p > {64'd0, cap}) return cap;
      return p[63:0];
   endfunction

   function longint coef(int k, int i);
      logic [20:0] v;
      v = row[k] >> (21 * i);
      return longint'($signed(v));
   endfunction

   function longint wrap_axis(longint d, logic [63:0] len);
      longint l, h;
      l = longint'(len);
      h = longint'(len >> 1);
      if (d > h) return d - l;
      if (d < -h) return d + l;
      return d;
   endfunction

   function longint sat_sum(longint s, longint c);
      longint r;
      r = s + c;
      if (r > 64'sd140737488355327) return 64'sd140737488355327;
      if (r < -64'sd140737488355328) return -64'sd140737488355328;
      return r;
   endfunction

   function longint force_term(longint f, longint x);
      longint m;
      logic [63:0] af, ax;
      af = (f < 0) ? -f : f;
      ax = (x < 0) ? -x : x;
      m = longint'(scaled_mul(af, ax, 24, 64'd140737488355327));
      return ((f < 0) != (x < 0)) ? -m : m;
   endfunction

   function void accumulate_pair(logic [31:0] h[3], logic [31:0] n[3]);
      longint d[3], t[3], s, f, e;
      logic [63:0] lens[3], r2, rr, i2, i4, i6, i8, i12, i14, cap62, ones;
      cap62 = 64'h3FFF_FFFF_FFFF_FFFF;
      ones = '1;
      lens[0] = box_xy[31:0]; lens[1] = box_xy[63:32]; lens[2] = box_z;
      r2 = 0;
      for (int i = 0; i < 3; i++)
         d[i] = wrap_axis(longint'({32'd0, n[i]}) - longint'({32'd0, h[i]}), lens[i]);
      for (int i = 0; i < 3; i++) begin
         s = 0;
         for (int k = 0; k < 3; k++) s += d[k] * coef(k, i);
         s = s / 524288;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         t[i] = s;
         r2 += s * s;
      end
      if (r2 > (cut_sq << 24)) return;
      rr = r2 >> 24;
      if (rr == 0) return;
      i2 = ones / rr;
      i4 = scaled_mul(i2, i2, 40, ones);
      i6 = scaled_mul(i2, i4, 40, ones);
      i8 = scaled_mul(i4, i4, 40, ones);
      i12 = scaled_mul(i4, i8, 40, ones);
      i14 = scaled_mul(i6, i8, 40, ones);
      f = longint'(scaled_mul(fcoef[31:0], i8, 32, cap62))
         - longint'(scaled_mul(fcoef[63:32], i14, 32, cap62));
      e = (longint'(scaled_mul(ecoef[31:0], i12, 32, cap62))
         - longint'(scaled_mul(ecoef[63:32], i6, 32, cap62))) / 2;
      if (e > 64'sd140737488355327) e = 64'sd140737488355327;
      if (e < -64'sd140737488355327) e = -64'sd140737488355327;
      sfx = sat_sum(sfx, force_term(f, t[0]));
      sfy = sat_sum(sfy, force_term(f, t[1]));
      sfz = sat_sum(sfz, force_term(f, t[2]));
      spe = sat_sum(spe, e);
   endfunction

   function void note_word(logic [31:0] h[3], logic [31:0] n[3], bit pv, bit last);
      if (pv) accumulate_pair(h, n);
      if (last) begin
         exp_fx.push_back(sfx[47:0]);
         exp_fy.push_back(sfy[47:0]);
         exp_fz.push_back(sfz[47:0]);
         exp_pe.push_back(spe[47:0]);
         sfx = 0; sfy = 0; sfz = 0; spe = 0;
      end
   endfunction

   function void report(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endfunction

   function void check_sums(logic [47:0] fx, logic [47:0] fy, logic [47:0] fz,
                            logic [47:0] pe);
      if (exp_fx.size() == 0) begin
         $display("mismatch: result word with nothing expected");
         errors++;
         return;
      end
      if (fx !== exp_fx[0]) report("force_x", fx, exp_fx[0]);
      if (fy !== exp_fy[0]) report("force_y", fy, exp_fy[0]);
      if (fz !== exp_fz[0]) report("force_z", fz, exp_fz[0]);
      if (pe !== exp_pe[0]) report("pot_energy", pe, exp_pe[0]);
      void'(exp_fx.pop_front()); void'(exp_fy.pop_front());
      void'(exp_fz.pop_front()); void'(exp_pe.pop_front());
   endfunction

   function int pending();
      return exp_fx.size();
   endfunction
endclass

module lennard_jones_pair_force_tb;
   import ljpf_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_home_x = 0, req_home_y = 0, req_home_z = 0;
   logic [31:0] req_nbr_x = 0, req_nbr_y = 0, req_nbr_z = 0;
   logic req_pair_valid = 0, req_last_neighbor = 0;
   logic rsp_valid;
   logic rsp_stall = 1;
   logic signed [47:0] rsp_force_x, rsp_force_y, rsp_force_z, rsp_pot_energy;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [63:0] csr_data = 0;

   force_sum_board board;
   bit hold_off = 0;

   lennard_jones_pair_force dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   task automatic write_reg(logic [3:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
   endtask

   task automatic send_word(logic [31:0] h[3], logic [31:0] n[3], bit pv, bit last,
                            bit nogap);
      int gap;
      gap = nogap ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_home_x <= h[0]; req_home_y <= h[1]; req_home_z <= h[2];
      req_nbr_x <= n[0]; req_nbr_y <= n[1]; req_nbr_z <= n[2];
      req_pair_valid <= pv;
      req_last_neighbor <= last;
      do @(posedge clock); while (req_stall);
      board.note_word(h, n, pv, last);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [62:0] pack_row(int a, int b, int c);
      logic [20:0] ea, eb, ec;
      ea = a; eb = b; ec = c;
      return {ec, eb, ea};
   endfunction

   task automatic set_config(int mode);
      logic [63:0] v[8];
      case (mode)
         0: begin
            v[0] = {32'h0A00_0000, 32'h0A00_0000}; v[1] = 32'h0A00_0000;
            v[2] = pack_row(1 << 19, 0, 0); v[3] = pack_row(0, 1 << 19, 0);
            v[4] = pack_row(0, 0, 1 << 19); v[5] = 32'h1000_0000;
            v[6] = {32'h0001_8000, 32'h0003_0000}; v[7] = {32'h0000_4000, 32'h0002_0000};
         end
         1: begin
            v[0] = 0; v[1] = 0; v[2] = {1'b0, 63'h7FFF_FFFF_FFFF_FFFF};
            v[3] = 0; v[4] = pack_row(-(1 << 20), (1 << 20) - 1, 12345);
            v[5] = 32'hFFFF_FFFF; v[6] = '1; v[7] = '1;
         end
         2: begin
            v[0] = '1; v[1] = 32'hFFFF_FFFF;
            v[2] = pack_row(-(1 << 20), 0, 1 << 18); v[3] = pack_row(3 << 17, -(1 << 19), 0);
            v[4] = pack_row(0, 1 << 18, (1 << 20) - 1); v[5] = 0; v[6] = 0; v[7] = 0;
         end
         default: begin
            v[0] = {$urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000)};
            v[1] = $urandom_range(0, 32'h2000_0000);
            for (int k = 0; k < 3; k++) v[2 + k] = {$urandom, $urandom};
            v[5] = $urandom;
            v[6] = {$urandom, $urandom}; v[7] = {$urandom, $urandom};
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
      write_reg(4'd9, {$urandom, $urandom});
      csr_valid <= 0;
   endtask

   task automatic near_pair(output logic [31:0] h[3], output logic [31:0] n[3]);
      for (int a = 0; a < 3; a++) begin
         h[a] = $urandom;
         n[a] = h[a] + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      end
   endtask

   task automatic run_random(int count, bit pressure_phase);
      logic [31:0] h[3], n[3];
      bit pv, last;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: for (int a = 0; a < 3; a++) begin h[a] = $urandom; n[a] = $urandom; end
            1: for (int a = 0; a < 3; a++) begin h[a] = $urandom; n[a] = h[a]; end
            default: near_pair(h, n);
         endcase
         pv = ($urandom_range(0, 7) != 0);
         last = ($urandom_range(0, 4) == 0);
         send_word(h, n, pv, last, pressure_phase);
      end
   endtask

   initial begin
      logic [31:0] h[3], n[3];
      board = new();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_config(0);
      h = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0000};
      n = '{32'h0200_0000, 32'h0100_0000, 32'h0100_0000};
      send_word(h, n, 1, 0, 0);
      n = '{32'h0900_0000, 32'h0180_0000, 32'h0080_0000};
      send_word(h, n, 1, 1, 0);
      send_word(h, h, 1, 1, 0);
      send_word(h, n, 0, 1, 0);
      send_word(h, n, 0, 0, 0);
      h = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
      n = '{32'h0, 32'hFFFF_FFFF, 32'h0};
      send_word(h, n, 1, 0, 0);
      n = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFF0};
      send_word(h, n, 1, 1, 0);
      drain();

      set_config(1);
      h = '{32'h0, 32'h0, 32'h0};
      n = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      send_word(h, n, 1, 0, 0);
      n = '{32'h0000_1000, 32'h0000_0800, 32'h0000_0400};
      send_word(h, n, 1, 0, 0);
      send_word(h, n, 1, 1, 0);
      drain();

      set_config(2);
      send_word(h, n, 1, 1, 0);
      drain();

      set_config(0);
      run_random(500, 0);
      drain();

      hold_off = 1;
      run_random(40, 1);
      drain();

      for (int p = 0; p < 4; p++) begin
         set_config(3);
         run_random(290, 0);
         drain();
      end

      if (board.errors == 0 && board.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            hold_off = 0;
            rsp_stall <= 1;
            repeat (3000) @(posedge clock);
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
         board.check_sums(rsp_force_x, rsp_force_y, rsp_force_z, rsp_pot_energy);
      end
   end

   initial begin
      #(2_000_000 * 10);
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: sim.f
+incdir+sv
sv/ljpf_pkg.sv
sv/ljpf_mul.sv
sv/ljpf_recip.sv
sv/lennard_jones_pair_force.sv
dv/lennard_jones_pair_force_tb.sv
